### design/spi_pkg.sv
// shared types, widths and step functions for the segment pair intersection core
// no dependencies; imported by spi_div, spi_sqrt and the top level
package spi_pkg;

    localparam int CW   = 16;              // endpoint coordinate width
    localparam int FB   = 16;              // fraction bits of s and t
    localparam int PB   = 8;               // fraction bits of the point
    localparam int DW   = CW + 1;          // endpoint difference
    localparam int PW   = 2 * DW;          // cross product term
    localparam int NW   = PW + 1;          // cross product
    localparam int QW   = 32;              // s and t
    localparam int MW   = QW + DW;         // s times a difference
    localparam int SW   = MW + 1;          // per-segment point, Q(FB)
    localparam int TW   = SW + 1;          // sum / difference of points
    localparam int KSH  = FB + 1 - PB;     // midpoint shift
    localparam int PTW  = 24;              // point field
    localparam int CLW  = 31;              // clamped distance component
    localparam int SQW  = 2 * CLW + 1;     // sum of squares
    localparam int RW   = SQW - 2 * (FB - PB);
    localparam int RTW  = (RW + 1) / 2;    // root width
    localparam int TOLW = 25;
    localparam int MTW  = 16;              // min tolerance register

    // register byte addresses
    localparam logic [2:0] ADDR_MIN_TOL = 3'd0;

    typedef struct packed {
        logic                 par;
        logic                 cr;
        logic                 snx_a;
        logic                 snx_c;
        logic                 sny_a;
        logic                 sny_c;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [DW-1:0] ex;
        logic signed [DW-1:0] ey;
        logic signed [DW-1:0] fx;
        logic signed [DW-1:0] fy;
    } t_div_side;

    typedef struct packed {
        logic neg_s;
        logic neg_t;
        logic sat_s;
        logic sat_t;
    } t_div_ctl;

    typedef struct packed {
        logic                  par;
        logic                  cr;
        logic signed [QW-1:0]  s;
        logic signed [QW-1:0]  t;
        logic signed [PTW-1:0] px;
        logic signed [PTW-1:0] py;
    } t_sq_side;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [NW:0] div_step(input logic [NW-1:0] rem, input logic din,
                                             input logic [NW-1:0] ud);
        logic [NW:0] t;
        logic [NW:0] d;
        t = {rem, din};
        d = t - {1'b0, ud};
        if (t >= {1'b0, ud}) begin
            return {1'b1, d[NW-1:0]};
        end
        return {1'b0, t[NW-1:0]};
    endfunction

    // apply sign to a rounded magnitude and saturate to the signed range
    function automatic logic [QW-1:0] sign_sat(input logic [QW:0] m, input logic neg);
        logic [QW-1:0] r;
        if (neg) begin
            if (m[QW] || (m[QW-1] && (|m[QW-2:0]))) begin
                r = {1'b1, {(QW-1){1'b0}}};
            end else begin
                r = -m[QW-1:0];
            end
        end else begin
            if (m[QW] || m[QW-1]) begin
                r = {1'b0, {(QW-1){1'b1}}};
            end else begin
                r = m[QW-1:0];
            end
        end
        return r;
    endfunction

    // one digit of the bitwise integer square root: {remainder, partial root}
    function automatic logic [2*RW-1:0] sqrt_step(input logic [RW-1:0] x,
                                                  input logic [RW-1:0] res,
                                                  input logic [RW-1:0] b);
        logic [RW:0]   rb;
        logic [RW-1:0] nx;
        logic [RW-1:0] nr;
        rb = {1'b0, res} + {1'b0, b};
        if ({1'b0, x} >= rb) begin
            nx = x - rb[RW-1:0];
            nr = (res >> 1) + b;
        end else begin
            nx = x;
            nr = res >> 1;
        end
        return {nx, nr};
    endfunction

endpackage

### design/segment_pair_intersection_core.sv
// segment pair intersection core: accepts one request per cycle while the output is not
// stalled; the 32-stage quotient pipeline and the 24-stage root pipeline set the
// depth, and one global stall holds every stage while a result waits at the output.
// synchronous active-low reset clears the valid bits and sets min_tolerance to 1
// depends on spi_pkg, spi_div, spi_sqrt
module segment_pair_intersection_core
    import spi_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // ax, ay, bx, by_coord, cx, cy, dx, dy
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,   // s_value, t_value, point_x, point_y, tolerance
    output logic [1:0]   m_axis_tuser,   // parallel, crosses
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic ce;
    logic [MTW-1:0] r_min_tol;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_tol <= MTW'(1);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_min_tol <= pwdata[MTW-1:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-MTW){1'b0}}, r_min_tol};

    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    logic signed [CW-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy, in_dx, in_dy;
    assign in_ax = s_axis_tdata[15:0];
    assign in_ay = s_axis_tdata[31:16];
    assign in_bx = s_axis_tdata[47:32];
    assign in_by = s_axis_tdata[63:48];
    assign in_cx = s_axis_tdata[79:64];
    assign in_cy = s_axis_tdata[95:80];
    assign in_dx = s_axis_tdata[111:96];
    assign in_dy = s_axis_tdata[127:112];

    // stage 1: differences
    logic                 r1_v;
    t_div_side            r1_sd;
    logic signed [DW-1:0] r1_gx, r1_gy;
    // stage 2: cross product terms
    logic                 r2_v;
    t_div_side            r2_sd;
    logic signed [PW-1:0] r2_exfy, r2_eyfx, r2_gxfy, r2_gyfx, r2_gxey, r2_gyex;
    // stage 3: cross products
    logic                 r3_v;
    t_div_side            r3_sd;
    logic signed [NW-1:0] r3_den, r3_ns, r3_nt;
    // stage 4: magnitudes
    logic                 r4_v;
    t_div_side            r4_sd;
    logic [NW-1:0]        r4_us, r4_ut, r4_ud;
    logic                 r4_sgn_ok;
    t_div_ctl             r4_ctl;
    // stage 5: range checks
    logic                 r5_v;
    t_div_side            r5_sd;
    logic [NW-1:0]        r5_us, r5_ut, r5_ud;
    t_div_ctl             r5_ctl;

    t_div_side            n_sd4, n_sd5;
    t_div_ctl             n_ctl5;

    always_comb begin
        n_sd4        = r3_sd;
        n_sd4.par    = r3_den == '0;
        n_sd5        = r4_sd;
        n_sd5.cr     = r4_sgn_ok && (r4_us < r4_ud) && (r4_ut < r4_ud);
        n_ctl5       = r4_ctl;
        // quotient would not fit the integer bits of the result
        n_ctl5.sat_s = {{FB{1'b0}}, r4_us} >= {r4_ud, {FB{1'b0}}};
        n_ctl5.sat_t = {{FB{1'b0}}, r4_ut} >= {r4_ud, {FB{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (ce) begin
            r1_v        <= s_axis_tvalid;
            r1_sd.par   <= 1'b0;
            r1_sd.cr    <= 1'b0;
            r1_sd.snx_a <= in_ax == in_bx;
            r1_sd.snx_c <= in_cx == in_dx;
            r1_sd.sny_a <= in_ay == in_by;
            r1_sd.sny_c <= in_cy == in_dy;
            r1_sd.ax    <= in_ax;
            r1_sd.ay    <= in_ay;
            r1_sd.cx    <= in_cx;
            r1_sd.cy    <= in_cy;
            r1_sd.ex    <= {in_bx[CW-1], in_bx} - {in_ax[CW-1], in_ax};
            r1_sd.ey    <= {in_by[CW-1], in_by} - {in_ay[CW-1], in_ay};
            r1_sd.fx    <= {in_dx[CW-1], in_dx} - {in_cx[CW-1], in_cx};
            r1_sd.fy    <= {in_dy[CW-1], in_dy} - {in_cy[CW-1], in_cy};
            r1_gx       <= {in_cx[CW-1], in_cx} - {in_ax[CW-1], in_ax};
            r1_gy       <= {in_cy[CW-1], in_cy} - {in_ay[CW-1], in_ay};

            r2_v    <= r1_v;
            r2_sd   <= r1_sd;
            r2_exfy <= r1_sd.ex * r1_sd.fy;
            r2_eyfx <= r1_sd.ey * r1_sd.fx;
            r2_gxfy <= r1_gx * r1_sd.fy;
            r2_gyfx <= r1_gy * r1_sd.fx;
            r2_gxey <= r1_gx * r1_sd.ey;
            r2_gyex <= r1_gy * r1_sd.ex;

            r3_v   <= r2_v;
            r3_sd  <= r2_sd;
            r3_den <= {r2_exfy[PW-1], r2_exfy} - {r2_eyfx[PW-1], r2_eyfx};
            r3_ns  <= {r2_gxfy[PW-1], r2_gxfy} - {r2_gyfx[PW-1], r2_gyfx};
            r3_nt  <= {r2_gxey[PW-1], r2_gxey} - {r2_gyex[PW-1], r2_gyex};

            r4_v         <= r3_v;
            r4_sd        <= n_sd4;
            r4_us        <= r3_ns[NW-1] ? -r3_ns : r3_ns;
            r4_ut        <= r3_nt[NW-1] ? -r3_nt : r3_nt;
            r4_ud        <= r3_den[NW-1] ? -r3_den : r3_den;
            r4_ctl.neg_s <= r3_ns[NW-1] ^ r3_den[NW-1];
            r4_ctl.neg_t <= r3_nt[NW-1] ^ r3_den[NW-1];
            r4_ctl.sat_s <= 1'b0;
            r4_ctl.sat_t <= 1'b0;
            r4_sgn_ok    <= (r3_ns != '0) && (r3_nt != '0)
                            && (r3_ns[NW-1] == r3_den[NW-1])
                            && (r3_nt[NW-1] == r3_den[NW-1]);

            r5_v   <= r4_v;
            r5_sd  <= n_sd5;
            r5_us  <= r4_us;
            r5_ut  <= r4_ut;
            r5_ud  <= r4_ud;
            r5_ctl <= n_ctl5;
        end
    end

    logic                 dv;
    logic signed [QW-1:0] dq_s, dq_t;
    t_div_side            dsd;

    spi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r5_v),
        .i_un_s  (r5_us),
        .i_un_t  (r5_ut),
        .i_ud    (r5_ud),
        .i_ctl   (r5_ctl),
        .i_side  (r5_sd),
        .o_valid (dv),
        .o_s     (dq_s),
        .o_t     (dq_t),
        .o_side  (dsd)
    );

    // point stages
    logic                 rp1_v, rp2_v, rp3_v, rp4_v, rp5_v;
    t_div_side            rp1_sd, rp2_sd, rp3_sd;
    logic signed [QW-1:0] rp1_s, rp1_t, rp2_s, rp2_t, rp3_s, rp3_t;
    logic signed [MW-1:0] rp1_msx, rp1_msy, rp1_mtx, rp1_mty;
    logic signed [SW-1:0] rp2_psx, rp2_psy, rp2_ptx, rp2_pty;
    logic signed [TW-1:0] rp3_sumx, rp3_sumy, rp3_dfx, rp3_dfy;
    t_sq_side             rp4_sd, rp5_sd;
    logic [CLW-1:0]       rp4_mx, rp4_my;
    logic [2*CLW-1:0]     rp5_sqx, rp5_sqy;

    logic signed [TW-1:0] n_shx, n_shy;
    logic [TW-1:0]        n_ax, n_ay;
    logic [PTW-1:0]       n_px, n_py;
    logic [SQW-1:0]       n_ssum;

    always_comb begin
        n_shx = (rp3_sumx + TW'(1 << (KSH - 1))) >>> KSH;
        n_shy = (rp3_sumy + TW'(1 << (KSH - 1))) >>> KSH;
        if ((&n_shx[TW-1:PTW-1]) || !(|n_shx[TW-1:PTW-1])) begin
            n_px = n_shx[PTW-1:0];
        end else begin
            n_px = {n_shx[TW-1], {(PTW-1){!n_shx[TW-1]}}};
        end
        if ((&n_shy[TW-1:PTW-1]) || !(|n_shy[TW-1:PTW-1])) begin
            n_py = n_shy[PTW-1:0];
        end else begin
            n_py = {n_shy[TW-1], {(PTW-1){!n_shy[TW-1]}}};
        end
        // a horizontal or vertical segment gives the exact coordinate
        if (rp3_sd.snx_a) begin
            n_px = PTW'({rp3_sd.ax, {PB{1'b0}}});
        end else if (rp3_sd.snx_c) begin
            n_px = PTW'({rp3_sd.cx, {PB{1'b0}}});
        end
        if (rp3_sd.sny_a) begin
            n_py = PTW'({rp3_sd.ay, {PB{1'b0}}});
        end else if (rp3_sd.sny_c) begin
            n_py = PTW'({rp3_sd.cy, {PB{1'b0}}});
        end
        n_ax   = rp3_dfx[TW-1] ? -rp3_dfx : rp3_dfx;
        n_ay   = rp3_dfy[TW-1] ? -rp3_dfy : rp3_dfy;
        n_ssum = {1'b0, rp5_sqx} + {1'b0, rp5_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp1_v <= 1'b0;
            rp2_v <= 1'b0;
            rp3_v <= 1'b0;
            rp4_v <= 1'b0;
            rp5_v <= 1'b0;
        end else if (ce) begin
            rp1_v   <= dv;
            rp1_sd  <= dsd;
            rp1_s   <= dq_s;
            rp1_t   <= dq_t;
            rp1_msx <= dq_s * dsd.ex;
            rp1_msy <= dq_s * dsd.ey;
            rp1_mtx <= dq_t * dsd.fx;
            rp1_mty <= dq_t * dsd.fy;

            rp2_v   <= rp1_v;
            rp2_sd  <= rp1_sd;
            rp2_s   <= rp1_s;
            rp2_t   <= rp1_t;
            rp2_psx <= SW'($signed({rp1_sd.ax, {FB{1'b0}}})) + {rp1_msx[MW-1], rp1_msx};
            rp2_psy <= SW'($signed({rp1_sd.ay, {FB{1'b0}}})) + {rp1_msy[MW-1], rp1_msy};
            rp2_ptx <= SW'($signed({rp1_sd.cx, {FB{1'b0}}})) + {rp1_mtx[MW-1], rp1_mtx};
            rp2_pty <= SW'($signed({rp1_sd.cy, {FB{1'b0}}})) + {rp1_mty[MW-1], rp1_mty};

            rp3_v    <= rp2_v;
            rp3_sd   <= rp2_sd;
            rp3_s    <= rp2_s;
            rp3_t    <= rp2_t;
            rp3_sumx <= {rp2_psx[SW-1], rp2_psx} + {rp2_ptx[SW-1], rp2_ptx};
            rp3_sumy <= {rp2_psy[SW-1], rp2_psy} + {rp2_pty[SW-1], rp2_pty};
            rp3_dfx  <= {rp2_psx[SW-1], rp2_psx} - {rp2_ptx[SW-1], rp2_ptx};
            rp3_dfy  <= {rp2_psy[SW-1], rp2_psy} - {rp2_pty[SW-1], rp2_pty};

            rp4_v      <= rp3_v;
            rp4_sd.par <= rp3_sd.par;
            rp4_sd.cr  <= rp3_sd.cr;
            rp4_sd.s   <= rp3_s;
            rp4_sd.t   <= rp3_t;
            rp4_sd.px  <= n_px;
            rp4_sd.py  <= n_py;
            rp4_mx     <= (|n_ax[TW-1:CLW]) ? {CLW{1'b1}} : n_ax[CLW-1:0];
            rp4_my     <= (|n_ay[TW-1:CLW]) ? {CLW{1'b1}} : n_ay[CLW-1:0];

            rp5_v   <= rp4_v;
            rp5_sd  <= rp4_sd;
            rp5_sqx <= rp4_mx * rp4_mx;
            rp5_sqy <= rp4_my * rp4_my;
        end
    end

    logic           sv;
    logic [RTW-1:0] sroot;
    t_sq_side       ssd;

    spi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (rp5_v),
        .i_x     (n_ssum[SQW-1:2*(FB-PB)]),
        .i_side  (rp5_sd),
        .o_valid (sv),
        .o_root  (sroot),
        .o_side  (ssd)
    );

    // output register
    logic                 r_ov;
    logic                 r_par, r_cr;
    logic [QW-1:0]        r_s, r_t;
    logic [PTW-1:0]       r_px, r_py;
    logic [TOLW-1:0]      r_tol;
    logic [TOLW-1:0]      n_tol;

    always_comb begin
        n_tol = TOLW'(sroot);
        if (n_tol < TOLW'(r_min_tol)) begin
            n_tol = TOLW'(r_min_tol);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ce) begin
            r_ov  <= sv;
            r_par <= ssd.par;
            r_cr  <= ssd.cr && !ssd.par;
            r_s   <= ssd.par ? '0 : ssd.s;
            r_t   <= ssd.par ? '0 : ssd.t;
            r_px  <= (ssd.cr && !ssd.par) ? ssd.px : '0;
            r_py  <= (ssd.cr && !ssd.par) ? ssd.py : '0;
            r_tol <= (ssd.cr && !ssd.par) ? n_tol : '0;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = {r_cr, r_par};
    assign m_axis_tdata  = {7'd0, r_tol, r_py, r_px, r_t, r_s};

endmodule

### design/spi_div.sv
// pipelined restoring divider for s and t, one quotient bit per stage, two lanes
// depends on spi_pkg
module spi_div
    import spi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  logic [NW-1:0]        i_un_s,
    input  logic [NW-1:0]        i_un_t,
    input  logic [NW-1:0]        i_ud,
    input  t_div_ctl             i_ctl,
    input  t_div_side            i_side,
    output logic                 o_valid,
    output logic signed [QW-1:0] o_s,
    output logic signed [QW-1:0] o_t,
    output t_div_side            o_side
);

    logic [NW-1:0] r_rem_s [0:QW];
    logic [NW-1:0] r_rem_t [0:QW];
    logic [QW-1:0] r_lo_s  [0:QW];
    logic [QW-1:0] r_lo_t  [0:QW];
    logic [QW-1:0] r_q_s   [0:QW];
    logic [QW-1:0] r_q_t   [0:QW];
    logic [NW-1:0] r_ud    [0:QW];
    t_div_ctl      r_ctl   [0:QW];
    t_div_side     r_sd    [0:QW];
    logic          r_v     [0:QW];

    logic [QW:0]   r_m_s;
    logic [QW:0]   r_m_t;
    t_div_ctl      r_mctl;
    t_div_side     r_msd;
    logic          r_mv;

    logic [QW-1:0] r_os;
    logic [QW-1:0] r_ot;
    t_div_side     r_osd;
    logic          r_ov;

    // stage 0: partial remainder starts from the integer part of the dividend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0]     <= i_valid;
            r_rem_s[0] <= NW'(i_un_s[NW-1:FB]);
            r_rem_t[0] <= NW'(i_un_t[NW-1:FB]);
            r_lo_s[0]  <= {i_un_s[FB-1:0], {(QW-FB){1'b0}}};
            r_lo_t[0]  <= {i_un_t[FB-1:0], {(QW-FB){1'b0}}};
            r_q_s[0]   <= '0;
            r_q_t[0]   <= '0;
            r_ud[0]    <= i_ud;
            r_ctl[0]   <= i_ctl;
            r_sd[0]    <= i_side;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [NW:0] n_ss;
        logic [NW:0] n_st;
        assign n_ss = div_step(r_rem_s[j], r_lo_s[j][QW-1], r_ud[j]);
        assign n_st = div_step(r_rem_t[j], r_lo_t[j][QW-1], r_ud[j]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[j+1]     <= r_v[j];
                r_rem_s[j+1] <= n_ss[NW-1:0];
                r_rem_t[j+1] <= n_st[NW-1:0];
                r_lo_s[j+1]  <= r_lo_s[j] << 1;
                r_lo_t[j+1]  <= r_lo_t[j] << 1;
                r_q_s[j+1]   <= {r_q_s[j][QW-2:0], n_ss[NW]};
                r_q_t[j+1]   <= {r_q_t[j][QW-2:0], n_st[NW]};
                r_ud[j+1]    <= r_ud[j];
                r_ctl[j+1]   <= r_ctl[j];
                r_sd[j+1]    <= r_sd[j];
            end
        end
    end

    // round half away from zero on the magnitude, overflow forces 2^QW; then apply the sign and saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_ce) begin
            r_mv   <= r_v[QW];
            r_mctl <= r_ctl[QW];
            r_msd  <= r_sd[QW];
            if (r_ctl[QW].sat_s) begin
                r_m_s <= {1'b1, {QW{1'b0}}};
            end else begin
                r_m_s <= {1'b0, r_q_s[QW]}
                         + (QW+1)'(r_rem_s[QW] >= (r_ud[QW] - r_rem_s[QW]));
            end
            if (r_ctl[QW].sat_t) begin
                r_m_t <= {1'b1, {QW{1'b0}}};
            end else begin
                r_m_t <= {1'b0, r_q_t[QW]}
                         + (QW+1)'(r_rem_t[QW] >= (r_ud[QW] - r_rem_t[QW]));
            end
            r_ov  <= r_mv;
            r_os  <= sign_sat(r_m_s, r_mctl.neg_s);
            r_ot  <= sign_sat(r_m_t, r_mctl.neg_t);
            r_osd <= r_msd;
        end
    end

    assign o_valid = r_ov;
    assign o_s     = r_os;
    assign o_t     = r_ot;
    assign o_side  = r_osd;

endmodule

### design/spi_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on spi_pkg
module spi_sqrt
    import spi_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_valid,
    input  logic [RW-1:0]  i_x,
    input  t_sq_side       i_side,
    output logic           o_valid,
    output logic [RTW-1:0] o_root,
    output t_sq_side       o_side
);

    logic [RW-1:0] r_x  [0:RTW];
    logic [RW-1:0] r_r  [0:RTW];
    t_sq_side      r_sd [0:RTW];
    logic          r_v  [0:RTW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0]  <= i_valid;
            r_x[0]  <= i_x;
            r_r[0]  <= '0;
            r_sd[0] <= i_side;
        end
    end

    for (genvar j = 0; j < RTW; j++) begin : g_stage
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (RTW - 1 - j));
        logic [2*RW-1:0] n_st;
        assign n_st = sqrt_step(r_x[j], r_r[j], BIT);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[j+1]  <= r_v[j];
                r_x[j+1]  <= n_st[2*RW-1:RW];
                r_r[j+1]  <= n_st[RW-1:0];
                r_sd[j+1] <= r_sd[j];
            end
        end
    end

    assign o_valid = r_v[RTW];
    assign o_root  = r_r[RTW][RTW-1:0];
    assign o_side  = r_sd[RTW];

endmodule
